/* rtl/cursor_address_formatter_top_assert.svh */
// assertion macros shared by the cursor address formatter checker
// expects clk and rst_n in the scope where a macro is used
`ifndef CURSOR_ADDRESS_FORMATTER_TOP_ASSERT_SVH
`define CURSOR_ADDRESS_FORMATTER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define CAF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define CAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/caf_pkg.sv */
// shared types, character codes and divider constants for the cursor address formatter
// no dependencies
`default_nettype none

package caf_pkg;

  // coordinate width, values wrap at this many bits
  localparam int COORD_BITS = 12;
  localparam int CHAR_BITS  = 8;
  localparam int START_BITS = 10;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CHAR_BITS-1:0]  char_t;

  // reciprocal multipliers for division by ten and by a hundred
  localparam int DIV10_SHIFT   = COORD_BITS + 4;
  localparam int DIV10_MULT    = ((1 << DIV10_SHIFT) + 9) / 10;
  localparam int PROD10_BITS   = COORD_BITS + DIV10_SHIFT;
  localparam int DIV100_SHIFT  = COORD_BITS + 8;
  localparam int DIV100_MULT   = ((1 << DIV100_SHIFT) + 99) / 100;
  localparam int PROD100_BITS  = COORD_BITS + DIV100_SHIFT;

  localparam int TEN     = 10;
  localparam int HUNDRED = 100;

  // format characters
  localparam char_t CH_PERCENT = 8'h25;
  localparam char_t CH_PLUS    = 8'h2B;
  localparam char_t CH_DOT     = 8'h2E;
  localparam char_t CH_TWO     = 8'h32;
  localparam char_t CH_THREE   = 8'h33;
  localparam char_t CH_LOWER_D = 8'h64;
  localparam char_t CH_LOWER_I = 8'h69;
  localparam char_t CH_LOWER_R = 8'h72;
  localparam char_t DIGIT_BIAS = 8'h30;

  // parser state, one-hot
  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_ESCAPE = 4'b0010,
    MODE_PLUS   = 4'b0100,
    MODE_SILENT = 4'b1000
  } mode_t;

  // result kinds as seen on the output channel
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // what a queued job emits before its marker
  typedef enum logic [1:0] {
    BODY_NONE   = 2'd0,
    BODY_BYTE   = 2'd1,
    BODY_DIGITS = 2'd2
  } body_t;

  // marker that closes a queued job
  typedef enum logic [1:0] {
    TAIL_NONE  = 2'd0,
    TAIL_END   = 2'd1,
    TAIL_ERROR = 2'd2
  } tail_t;

  // number of decimal digits to print
  localparam logic [1:0] DIGITS_ONE   = 2'd1;
  localparam logic [1:0] DIGITS_TWO   = 2'd2;
  localparam logic [1:0] DIGITS_THREE = 2'd3;

  typedef struct packed {
    body_t      body;
    char_t      lit;
    coord_t     value;
    logic [1:0] ndig;
    tail_t      tail;
  } job_t;

  // job queue between the parser and the emitter
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  typedef logic [QUEUE_AW:0] qcount_t;

endpackage

`default_nettype wire

/* rtl/caf_in_if.sv */
// input channel of the cursor address formatter: one format character per word
// depends on caf_pkg
`default_nettype none

interface caf_in_if;
  logic                              valid;
  logic                              ready;
  caf_pkg::char_t                    format_char;
  logic                              first_char;
  logic                              final_char;
  logic [caf_pkg::START_BITS-1:0]    start_col;
  logic [caf_pkg::START_BITS-1:0]    start_line;

  modport source (
    output valid, format_char, first_char, final_char, start_col, start_line,
    input  ready
  );

  modport sink (
    input  valid, format_char, first_char, final_char, start_col, start_line,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/caf_out_if.sv */
// result channel of the cursor address formatter: one terminal byte or marker per word
// depends on caf_pkg
`default_nettype none

interface caf_out_if;
  logic           valid;
  logic           ready;
  logic [1:0]     out_kind;
  caf_pkg::char_t out_byte;
  logic           run_end;

  modport source (
    output valid, out_kind, out_byte, run_end,
    input  ready
  );

  modport sink (
    input  valid, out_kind, out_byte, run_end,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/caf_front.sv */
// parser front end: takes format characters, tracks escape state and coordinates,
// and pushes one job per character that produces output; depends on caf_pkg, caf_in_if
`default_nettype none

module caf_front (
  input  logic           clk,
  input  logic           rst_n,
  caf_in_if.sink         in_chan,
  input  logic           q_full,
  output logic           push,
  output caf_pkg::job_t  push_job
);

  caf_pkg::mode_t  mode_r, mode_nxt;
  logic            onc_r, onc_nxt;
  caf_pkg::coord_t cur_r, cur_nxt;
  caf_pkg::coord_t col_r, col_nxt;
  caf_pkg::coord_t line_r, line_nxt;

  caf_pkg::mode_t  mode_v;
  logic            onc_v;
  caf_pkg::coord_t cur_v;
  caf_pkg::coord_t col_v;
  caf_pkg::coord_t line_v;
  caf_pkg::coord_t plus_sum;
  logic            fmt_err;
  logic            do_switch;
  logic            accept;
  caf_pkg::job_t   job;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  // reload coordinates at the start of a string
  always_comb begin
    mode_v = mode_r;
    onc_v  = onc_r;
    cur_v  = cur_r;
    col_v  = col_r;
    line_v = line_r;
    if (in_chan.first_char) begin
      col_v  = caf_pkg::coord_t'(in_chan.start_col);
      line_v = caf_pkg::coord_t'(in_chan.start_line);
      onc_v  = 1'b0;
      cur_v  = caf_pkg::coord_t'(in_chan.start_line);
      mode_v = caf_pkg::MODE_NORMAL;
    end
  end

  assign plus_sum = cur_v + caf_pkg::coord_t'(in_chan.format_char);

  // character classification and next state
  always_comb begin
    mode_nxt  = mode_v;
    onc_nxt   = onc_v;
    cur_nxt   = cur_v;
    col_nxt   = col_v;
    line_nxt  = line_v;
    fmt_err   = 1'b0;
    do_switch = 1'b0;
    job.body  = caf_pkg::BODY_NONE;
    job.lit   = '0;
    job.value = cur_v;
    job.ndig  = caf_pkg::DIGITS_ONE;
    job.tail  = caf_pkg::TAIL_NONE;

    case (mode_v)
      caf_pkg::MODE_SILENT: begin
      end
      caf_pkg::MODE_PLUS: begin
        job.body  = caf_pkg::BODY_BYTE;
        job.lit   = caf_pkg::char_t'(plus_sum);
        cur_nxt   = plus_sum;
        do_switch = 1'b1;
        mode_nxt  = caf_pkg::MODE_NORMAL;
      end
      caf_pkg::MODE_NORMAL: begin
        if (in_chan.format_char != caf_pkg::CH_PERCENT) begin
          job.body = caf_pkg::BODY_BYTE;
          job.lit  = in_chan.format_char;
        end else if (in_chan.final_char) begin
          fmt_err = 1'b1;
        end else begin
          mode_nxt = caf_pkg::MODE_ESCAPE;
        end
      end
      caf_pkg::MODE_ESCAPE: begin
        mode_nxt = caf_pkg::MODE_NORMAL;
        case (in_chan.format_char)
          caf_pkg::CH_LOWER_D: begin
            job.body = caf_pkg::BODY_DIGITS;
            if (cur_v >= caf_pkg::coord_t'(caf_pkg::HUNDRED)) begin
              job.ndig = caf_pkg::DIGITS_THREE;
            end else if (cur_v >= caf_pkg::coord_t'(caf_pkg::TEN)) begin
              job.ndig = caf_pkg::DIGITS_TWO;
            end else begin
              job.ndig = caf_pkg::DIGITS_ONE;
            end
            do_switch = 1'b1;
          end
          caf_pkg::CH_TWO: begin
            job.body  = caf_pkg::BODY_DIGITS;
            job.ndig  = caf_pkg::DIGITS_TWO;
            do_switch = 1'b1;
          end
          caf_pkg::CH_THREE: begin
            job.body  = caf_pkg::BODY_DIGITS;
            job.ndig  = caf_pkg::DIGITS_THREE;
            do_switch = 1'b1;
          end
          caf_pkg::CH_PLUS: begin
            if (in_chan.final_char) begin
              job.body  = caf_pkg::BODY_BYTE;
              job.lit   = caf_pkg::char_t'(cur_v);
              do_switch = 1'b1;
            end else begin
              mode_nxt = caf_pkg::MODE_PLUS;
            end
          end
          caf_pkg::CH_DOT: begin
            job.body  = caf_pkg::BODY_BYTE;
            job.lit   = caf_pkg::char_t'(cur_v);
            do_switch = 1'b1;
          end
          caf_pkg::CH_LOWER_R: begin
            onc_nxt = 1'b1;
            cur_nxt = col_v;
          end
          caf_pkg::CH_LOWER_I: begin
            col_nxt  = col_v + 1'b1;
            line_nxt = line_v + 1'b1;
            cur_nxt  = cur_v + 1'b1;
          end
          caf_pkg::CH_PERCENT: begin
            job.body = caf_pkg::BODY_BYTE;
            job.lit  = caf_pkg::CH_PERCENT;
          end
          default: begin
            fmt_err = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase

    // swap between line and column after a value is printed
    if (do_switch) begin
      onc_nxt = !onc_v;
      cur_nxt = onc_v ? line_v : col_v;
    end

    // closing marker, none while silent
    if (mode_v != caf_pkg::MODE_SILENT) begin
      if (fmt_err) begin
        job.body = caf_pkg::BODY_NONE;
        job.tail = caf_pkg::TAIL_ERROR;
        mode_nxt = caf_pkg::MODE_SILENT;
      end else if (in_chan.final_char) begin
        job.tail = caf_pkg::TAIL_END;
        mode_nxt = caf_pkg::MODE_NORMAL;
      end
    end
  end

  assign push     = accept && ((job.body != caf_pkg::BODY_NONE) ||
                               (job.tail != caf_pkg::TAIL_NONE));
  assign push_job = job;

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= caf_pkg::MODE_NORMAL;
      onc_r  <= 1'b0;
      cur_r  <= '0;
      col_r  <= '0;
      line_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      onc_r  <= onc_nxt;
      cur_r  <= cur_nxt;
      col_r  <= col_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/caf_queue.sv */
// small job queue between the parser and the emitter
// depends on caf_pkg
`default_nettype none

module caf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  caf_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output caf_pkg::job_t  head_job,
  output logic           head_valid
);

  caf_pkg::job_t                  mem_r [caf_pkg::QUEUE_DEPTH];
  logic [caf_pkg::QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [caf_pkg::QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  caf_pkg::qcount_t               cnt_r, cnt_nxt;

  assign full       = (cnt_r == caf_pkg::qcount_t'(caf_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

/* rtl/caf_back.sv */
// emitter back end: splits values into decimal digits and sends result words one at a time
// depends on caf_pkg, caf_out_if
`default_nettype none

module caf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  caf_pkg::job_t  head_job,
  output logic           pop,
  caf_out_if.source      out_chan
);

  localparam int P10  = caf_pkg::PROD10_BITS;
  localparam int P100 = caf_pkg::PROD100_BITS;

  // quotient stage
  logic            a_valid_r, a_valid_nxt;
  caf_pkg::job_t   a_job_r;
  caf_pkg::coord_t a_q10_r;
  caf_pkg::coord_t a_q100_r;
  logic [P10-1:0]  prod10;
  logic [P100-1:0] prod100;

  // result stage
  logic            e_valid_r, e_valid_nxt;
  caf_pkg::kind_t  e_kind_r [4];
  caf_pkg::char_t  e_byte_r [4];
  logic [1:0]      e_idx_r, e_idx_nxt;
  logic [1:0]      e_last_r;

  logic            a_adv;
  logic            e_free;
  logic            e_done;
  logic            out_take;

  // digits and result list built from the quotient stage
  caf_pkg::coord_t dig_h, dig_t, dig_u;
  caf_pkg::char_t  byte_h, byte_t, byte_u;
  caf_pkg::kind_t  ld_kind [4];
  caf_pkg::char_t  ld_byte [4];
  logic [2:0]      ld_n;
  logic [1:0]      ld_last;

  assign out_take = out_chan.valid && out_chan.ready;
  assign e_done   = e_valid_r && out_chan.ready && (e_idx_r == e_last_r);
  assign e_free   = !e_valid_r || e_done;
  assign a_adv    = a_valid_r && e_free;
  assign pop      = head_valid && (!a_valid_r || a_adv);

  // reciprocal multiply for value / 10 and value / 100
  assign prod10  = P10'(head_job.value) * P10'(caf_pkg::DIV10_MULT);
  assign prod100 = P100'(head_job.value) * P100'(caf_pkg::DIV100_MULT);

  assign a_valid_nxt = pop ? 1'b1 : (a_adv ? 1'b0 : a_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_job_r  <= head_job;
      a_q10_r  <= caf_pkg::coord_t'(prod10 >> caf_pkg::DIV10_SHIFT);
      a_q100_r <= caf_pkg::coord_t'(prod100 >> caf_pkg::DIV100_SHIFT);
    end
  end

  // remainders by shift and add; tens drop the hundreds only when those are printed
  always_comb begin
    dig_h = a_q100_r;
    dig_u = a_job_r.value - ((a_q10_r << 3) + (a_q10_r << 1));
    if (a_job_r.ndig == caf_pkg::DIGITS_THREE) begin
      dig_t = a_q10_r - ((a_q100_r << 3) + (a_q100_r << 1));
    end else begin
      dig_t = a_q10_r;
    end
    byte_h = caf_pkg::char_t'(dig_h) | caf_pkg::DIGIT_BIAS;
    byte_t = caf_pkg::char_t'(dig_t) | caf_pkg::DIGIT_BIAS;
    byte_u = caf_pkg::char_t'(dig_u) | caf_pkg::DIGIT_BIAS;
  end

  // lay out the result words of one job
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ld_kind[k] = caf_pkg::KIND_BYTE;
      ld_byte[k] = '0;
    end
    ld_n = 3'd0;
    case (a_job_r.body)
      caf_pkg::BODY_BYTE: begin
        ld_byte[0] = a_job_r.lit;
        ld_n       = 3'd1;
      end
      caf_pkg::BODY_DIGITS: begin
        case (a_job_r.ndig)
          caf_pkg::DIGITS_THREE: begin
            ld_byte[0] = byte_h;
            ld_byte[1] = byte_t;
            ld_byte[2] = byte_u;
            ld_n       = 3'd3;
          end
          caf_pkg::DIGITS_TWO: begin
            ld_byte[0] = byte_t;
            ld_byte[1] = byte_u;
            ld_n       = 3'd2;
          end
          default: begin
            ld_byte[0] = byte_u;
            ld_n       = 3'd1;
          end
        endcase
      end
      default: begin
      end
    endcase
    case (a_job_r.tail)
      caf_pkg::TAIL_END: begin
        ld_kind[ld_n[1:0]] = caf_pkg::KIND_END;
        ld_byte[ld_n[1:0]] = '0;
        ld_n               = ld_n + 3'd1;
      end
      caf_pkg::TAIL_ERROR: begin
        ld_kind[ld_n[1:0]] = caf_pkg::KIND_ERROR;
        ld_byte[ld_n[1:0]] = '0;
        ld_n               = ld_n + 3'd1;
      end
      default: begin
      end
    endcase
    ld_last = 2'(ld_n - 3'd1);
  end

  // result stage control
  always_comb begin
    e_valid_nxt = e_valid_r;
    e_idx_nxt   = e_idx_r;
    if (a_adv) begin
      e_valid_nxt = 1'b1;
      e_idx_nxt   = '0;
    end else if (e_done) begin
      e_valid_nxt = 1'b0;
    end else if (out_take) begin
      e_idx_nxt = e_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
      e_idx_r   <= '0;
    end else begin
      e_valid_r <= e_valid_nxt;
      e_idx_r   <= e_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      e_kind_r <= ld_kind;
      e_byte_r <= ld_byte;
      e_last_r <= ld_last;
    end
  end

  // output word
  assign out_chan.valid    = e_valid_r;
  assign out_chan.out_kind = e_kind_r[e_idx_r];
  assign out_chan.out_byte = e_byte_r[e_idx_r];
  assign out_chan.run_end  = (e_idx_r == e_last_r);

endmodule

`default_nettype wire

/* rtl/cursor_address_formatter_top.sv */
// Cursor address formatter. Input words carry one character of a cursor
// addressing format string (with first_char / final_char flags and the
// destination column and line on the first character). Each input word
// produces zero to four result words: terminal bytes (kind 0), an end of
// string marker (kind 1) or a format error (kind 2). run_end is set on the
// last result word belonging to one input word.
// With the emitter idle, an accepted input word passes the job queue, the
// quotient stage and the result stage, where its first result word becomes
// valid. Input words are taken every cycle while the four-entry job queue
// has room; the emitter sends one result word per cycle while the receiver
// is ready, so the sustained rate is set by the result count: one word per
// input word for plain characters, up to four for a final three-digit value.
// Reset (synchronous, active low) clears the parser to normal mode with both
// coordinates at zero and empties the queue and the emitter.
// When the receiver stalls, the current result word holds steady, the queue
// fills, and in_chan.ready drops once it is full.
// depends on caf_pkg, caf_in_if, caf_out_if, caf_front, caf_queue, caf_back
`default_nettype none

module cursor_address_formatter_top (
  input  logic      clk,
  input  logic      rst_n,
  caf_in_if.sink    in_chan,
  caf_out_if.source out_chan
);

  logic          push;
  caf_pkg::job_t push_job;
  logic          q_full;
  logic          pop;
  caf_pkg::job_t head_job;
  logic          head_valid;

  // parser
  caf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // job queue
  caf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_job   (head_job),
    .head_valid (head_valid)
  );

  // digit split and result emitter
  caf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule

`default_nettype wire

/* rtl/caf_checker.sv */
// port-level checks on the result channel of the cursor address formatter
// depends on caf_pkg and cursor_address_formatter_top_assert.svh; bound to the top level
`default_nettype none
`include "cursor_address_formatter_top_assert.svh"

module caf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic       run_end
);

  // a stalled result word holds
  `CAF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_byte) && $stable(run_end), "result word changed while stalled")

  // an error closes the run of its input word
  `CAF_ASSERT(a_err_last, out_valid && (out_kind == caf_pkg::KIND_ERROR), run_end, "error word without run_end")

  // an end marker closes the run of its input word
  `CAF_ASSERT(a_end_last, out_valid && (out_kind == caf_pkg::KIND_END), run_end, "end word without run_end")

  // markers carry a zero byte
  `CAF_ASSERT(a_marker_zero, out_valid && (out_kind != caf_pkg::KIND_BYTE), out_byte == 8'h00, "marker word with non-zero byte")

endmodule

bind cursor_address_formatter_top caf_checker u_caf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.out_kind),
  .out_byte  (out_chan.out_byte),
  .run_end   (out_chan.run_end)
);

`default_nettype wire

/* tb/tb_cursor_address_formatter_top.sv */
// testbench for the cursor address formatter: directed table, then random format strings
// checked word by word against a predictor; depends on caf_pkg, caf_in_if, caf_out_if
`timescale 1ns / 1ps

module tb_cursor_address_formatter_top;

  typedef logic [caf_pkg::START_BITS-1:0] start_t;

  // one input word as the sender sees it
  typedef struct packed {
    caf_pkg::char_t ch;
    logic           first;
    logic           fin;
    start_t         col;
    start_t         line;
  } format_item_t;

  // one result word
  typedef struct packed {
    caf_pkg::kind_t kind;
    caf_pkg::char_t data;
    logic           last;
  } term_word_t;

  // directed row, with typed results where they are obvious (n_typed < 0: use predictor)
  typedef struct {
    format_item_t it;
    int           n_typed;
    term_word_t   w0;
    term_word_t   w1;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  caf_in_if  in_chan ();
  caf_out_if out_chan ();

  cursor_address_formatter_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  caf_pkg::mode_t  pr_mode;
  logic            pr_on_col;
  caf_pkg::coord_t pr_cur;
  caf_pkg::coord_t pr_col;
  caf_pkg::coord_t pr_line;

  term_word_t   step_words[$];
  term_word_t   expected_words[$];
  format_item_t pending_items[$];
  stim_row_t    directed_rows[$];

  int mismatch_count = 0;
  int sender_idle_pct;
  int receiver_idle_pct;
  int hold_request = 0;
  int hold_left = 0;

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t ns mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  function automatic void add_word(input caf_pkg::kind_t kind, input int value);
    step_words.push_back('{kind: kind, data: caf_pkg::char_t'(value), last: 1'b0});
  endfunction

  // move on to the other coordinate after a value has been printed
  function automatic void swap_coordinate();
    pr_on_col = ~pr_on_col;
    pr_cur    = pr_on_col ? pr_col : pr_line;
  endfunction

  // works out the result words of one accepted input word into step_words
  function automatic void predict_format_char(input format_item_t it);
    int   v;
    logic err;
    err = 1'b0;
    step_words.delete();
    if (it.first) begin
      pr_col    = caf_pkg::coord_t'(it.col);
      pr_line   = caf_pkg::coord_t'(it.line);
      pr_on_col = 1'b0;
      pr_cur    = pr_line;
      pr_mode   = caf_pkg::MODE_NORMAL;
    end
    if (pr_mode == caf_pkg::MODE_SILENT)
      return;
    case (pr_mode)
      caf_pkg::MODE_PLUS: begin
        pr_cur = pr_cur + caf_pkg::coord_t'(it.ch);
        add_word(caf_pkg::KIND_BYTE, pr_cur);
        swap_coordinate();
        pr_mode = caf_pkg::MODE_NORMAL;
      end
      caf_pkg::MODE_NORMAL: begin
        if (it.ch != caf_pkg::CH_PERCENT) add_word(caf_pkg::KIND_BYTE, it.ch);
        else if (it.fin) err = 1'b1;
        else pr_mode = caf_pkg::MODE_ESCAPE;
      end
      default: begin
        pr_mode = caf_pkg::MODE_NORMAL;
        v = int'(pr_cur);
        case (it.ch)
          caf_pkg::CH_LOWER_D, caf_pkg::CH_TWO, caf_pkg::CH_THREE: begin
            if (it.ch == caf_pkg::CH_THREE ||
                (it.ch == caf_pkg::CH_LOWER_D && v >= caf_pkg::HUNDRED)) begin
              add_word(caf_pkg::KIND_BYTE, (v / caf_pkg::HUNDRED) | caf_pkg::DIGIT_BIAS);
              v = v % caf_pkg::HUNDRED;
            end
            if (it.ch != caf_pkg::CH_LOWER_D || v >= caf_pkg::TEN ||
                int'(pr_cur) >= caf_pkg::HUNDRED)
              add_word(caf_pkg::KIND_BYTE, (v / caf_pkg::TEN) | caf_pkg::DIGIT_BIAS);
            add_word(caf_pkg::KIND_BYTE, (v % caf_pkg::TEN) | caf_pkg::DIGIT_BIAS);
            swap_coordinate();
          end
          caf_pkg::CH_PLUS: begin
            // plus as the last character adds nothing
            if (it.fin) begin
              add_word(caf_pkg::KIND_BYTE, pr_cur);
              swap_coordinate();
            end else begin
              pr_mode = caf_pkg::MODE_PLUS;
            end
          end
          caf_pkg::CH_DOT: begin
            add_word(caf_pkg::KIND_BYTE, pr_cur);
            swap_coordinate();
          end
          caf_pkg::CH_LOWER_R: begin
            pr_on_col = 1'b1;
            pr_cur    = pr_col;
          end
          caf_pkg::CH_LOWER_I: begin
            pr_col  = pr_col + 1'b1;
            pr_line = pr_line + 1'b1;
            pr_cur  = pr_cur + 1'b1;
          end
          caf_pkg::CH_PERCENT: add_word(caf_pkg::KIND_BYTE, caf_pkg::CH_PERCENT);
          default:             err = 1'b1;
        endcase
      end
    endcase
    if (err) begin
      step_words.delete();
      add_word(caf_pkg::KIND_ERROR, 0);
      pr_mode = caf_pkg::MODE_SILENT;
    end else if (it.fin) begin
      add_word(caf_pkg::KIND_END, 0);
      pr_mode = caf_pkg::MODE_NORMAL;
    end
    if (step_words.size() > 0)
      step_words[step_words.size()-1].last = 1'b1;
  endfunction

  function automatic void add_row(input caf_pkg::char_t ch, input logic first, input logic fin,
                                  input int col = 0, input int line = 0,
                                  input int n_typed = -1,
                                  input term_word_t w0 = '0, input term_word_t w1 = '0);
    stim_row_t r;
    r.it      = '{ch: ch, first: first, fin: fin,
                  col: start_t'(col), line: start_t'(line)};
    r.n_typed = n_typed;
    r.w0      = w0;
    r.w1      = w1;
    directed_rows.push_back(r);
  endfunction

  function automatic start_t pick_coord();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return start_t'($urandom_range(0, 9));
      3:       return start_t'($urandom_range(90, 110));
      default: return start_t'($urandom_range(0, 1023));
    endcase
  endfunction

  // one format string of random content, mostly well formed
  function automatic void queue_format_string();
    caf_pkg::char_t chs[$];
    caf_pkg::char_t c;
    int             n_elem;
    int             pick;
    logic           keep_coords;
    start_t         col;
    start_t         line;
    n_elem = $urandom_range(1, 5);
    for (int i = 0; i < n_elem; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        do c = caf_pkg::char_t'($urandom_range(0, 255)); while (c == caf_pkg::CH_PERCENT);
        chs.push_back(c);
      end else begin
        chs.push_back(caf_pkg::CH_PERCENT);
        if (pick < 42) chs.push_back(caf_pkg::CH_LOWER_D);
        else if (pick < 50) chs.push_back(caf_pkg::CH_TWO);
        else if (pick < 58) chs.push_back(caf_pkg::CH_THREE);
        else if (pick < 64) chs.push_back(caf_pkg::CH_DOT);
        else if (pick < 72) begin
          chs.push_back(caf_pkg::CH_PLUS);
          chs.push_back(caf_pkg::char_t'($urandom_range(0, 255)));
        end
        else if (pick < 78) chs.push_back(caf_pkg::CH_LOWER_R);
        else if (pick < 84) chs.push_back(caf_pkg::CH_LOWER_I);
        else if (pick < 89) chs.push_back(caf_pkg::CH_PERCENT);
        else if (pick < 93) begin
          // unknown escape
          do c = caf_pkg::char_t'($urandom_range(0, 255));
          while (c inside {caf_pkg::CH_LOWER_D, caf_pkg::CH_TWO, caf_pkg::CH_THREE,
                           caf_pkg::CH_DOT, caf_pkg::CH_PLUS, caf_pkg::CH_LOWER_R,
                           caf_pkg::CH_LOWER_I, caf_pkg::CH_PERCENT});
          chs.push_back(c);
        end
        else if (i == n_elem - 1) begin
          // lone '%' at the end is an error, '%+' at the end adds zero
          if ($urandom_range(0, 1) == 1) chs.push_back(caf_pkg::CH_PLUS);
        end
        else chs.push_back(caf_pkg::CH_LOWER_D);
      end
    end
    keep_coords = ($urandom_range(0, 19) == 0);
    col  = pick_coord();
    line = pick_coord();
    foreach (chs[i])
      pending_items.push_back('{ch: chs[i],
                                first: (i == 0) && !keep_coords,
                                fin: (i == chs.size() - 1),
                                col: (i == 0) ? col : start_t'($urandom_range(0, 1023)),
                                line: (i == 0) ? line : start_t'($urandom_range(0, 1023))});
  endfunction

  // offer one word, with random gaps before it, and wait for it to be taken
  task automatic send_item(input format_item_t it);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.format_char <= it.ch;
    in_chan.first_char  <= it.first;
    in_chan.final_char  <= it.fin;
    in_chan.start_col   <= it.col;
    in_chan.start_line  <= it.line;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // hold the sender until every expected word has come back
  task automatic wait_for_drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    term_word_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected word, kind", out_chan.out_kind, 0);
      end else begin
        want = expected_words.pop_front();
        if (out_chan.out_kind !== want.kind)
          note_mismatch("out_kind", out_chan.out_kind, want.kind);
        if (out_chan.out_byte !== want.data)
          note_mismatch("out_byte", out_chan.out_byte, want.data);
        if (out_chan.run_end !== want.last)
          note_mismatch("run_end", out_chan.run_end, want.last);
      end
    end
  end

  // run limit
  initial begin
    #800000;
    $display("status: fail");
    $finish;
  end

  // main sequence
  initial begin
    format_item_t it;
    int           sent;
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.format_char <= '0;
    in_chan.first_char  <= 1'b0;
    in_chan.final_char  <= 1'b0;
    in_chan.start_col   <= '0;
    in_chan.start_line  <= '0;
    pr_mode   = caf_pkg::MODE_NORMAL;
    pr_on_col = 1'b0;
    pr_cur    = '0;
    pr_col    = '0;
    pr_line   = '0;
    sender_idle_pct   = 37;
    receiver_idle_pct = 81;

    // directed: reset state, extremes, every escape, errors and recovery
    add_row(8'h00, 1'b0, 1'b0, 0, 0, 1, '{caf_pkg::KIND_BYTE, 8'h00, 1'b1});
    add_row(8'hFF, 1'b0, 1'b1, 0, 0, 2, '{caf_pkg::KIND_BYTE, 8'hFF, 1'b0},
            '{caf_pkg::KIND_END, 8'h00, 1'b1});
    add_row(caf_pkg::CH_PERCENT, 1'b1, 1'b0, 1023, 1023);
    add_row(caf_pkg::CH_THREE, 1'b0, 1'b0);
    add_row(caf_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_row(caf_pkg::CH_LOWER_D, 1'b0, 1'b0);
    add_row(caf_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_row(caf_pkg::CH_DOT, 1'b0, 1'b0);
    add_row(caf_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_row(caf_pkg::CH_PLUS, 1'b0, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0);
    add_row(caf_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_row(caf_pkg::CH_LOWER_R, 1'b0, 1'b0);
    add_row(caf_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_row(caf_pkg::CH_LOWER_I, 1'b0, 1'b0);
    add_row(caf_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_row(caf_pkg::CH_THREE, 1'b0, 1'b1);
    add_row(caf_pkg::CH_PERCENT, 1'b1, 1'b0, 5, 0);
    add_row(caf_pkg::CH_LOWER_D, 1'b0, 1'b0);
    add_row(caf_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_row(caf_pkg::CH_TWO, 1'b0, 1'b0);
    add_row(caf_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_row(caf_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_row(caf_pkg::CH_PERCENT, 1'b0, 1'b0);
    add_row(caf_pkg::CH_PLUS, 1'b0, 1'b1);
    add_row(caf_pkg::CH_PERCENT, 1'b1, 1'b0, 3, 4);
    add_row("x", 1'b0, 1'b0, 0, 0, 1, '{caf_pkg::KIND_ERROR, 8'h00, 1'b1});
    add_row("A", 1'b0, 1'b1, 0, 0, 0);
    add_row(caf_pkg::CH_PERCENT, 1'b1, 1'b1, 9, 9, 1, '{caf_pkg::KIND_ERROR, 8'h00, 1'b1});
    add_row("B", 1'b1, 1'b1, 0, 7);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].it);
      predict_format_char(directed_rows[i].it);
      if (directed_rows[i].n_typed < 0) begin
        foreach (step_words[j]) expected_words.push_back(step_words[j]);
      end else begin
        if (directed_rows[i].n_typed > 0) expected_words.push_back(directed_rows[i].w0);
        if (directed_rows[i].n_typed > 1) expected_words.push_back(directed_rows[i].w1);
      end
    end
    wait_for_drain();

    // random strings in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct   = (phase == 0) ? 37 : (phase == 1) ? 81 : 0;
      receiver_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 37 : 0;
      // long receiver hold-off while the sender keeps going, so the queue backs up
      if (phase == 2) hold_request = 150;
      sent = 0;
      while (sent < 110) begin
        if (pending_items.size() == 0) begin
          if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3))
              pending_items.push_back('{ch: caf_pkg::char_t'($urandom_range(0, 255)),
                                        first: 1'($urandom_range(0, 1)),
                                        fin: 1'($urandom_range(0, 1)),
                                        col: start_t'($urandom_range(0, 1023)),
                                        line: start_t'($urandom_range(0, 1023))});
          end else begin
            queue_format_string();
          end
        end
        it = pending_items.pop_front();
        send_item(it);
        predict_format_char(it);
        foreach (step_words[j]) expected_words.push_back(step_words[j]);
        sent++;
      end
      wait_for_drain();
    end

    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
